[hw/rtl/hre_pkg.sv]
// ============================================================================
// hre_pkg: shared constants and helpers for the hex record encoder
// Character codes, field widths, header slot codes and the small lookup
// functions used by the record sequencer.
// ============================================================================
package hre_pkg;

  localparam int RECORD_BYTES = 16;
  localparam int CNT_W        = $clog2(RECORD_BYTES + 1);
  localparam int IDX_W        = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

  // Record formats
  localparam logic [1:0] FMT_INTEL = 2'd0;

  // Configuration register indexes
  localparam logic CFG_FORMAT = 1'b0;
  localparam logic CFG_START  = 1'b1;

  // ASCII codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TEN   = 8'h3A;  // '0' + 10

  // Intel end line ":00000001FF" is END_INTEL_LAST + 1 characters long
  localparam logic [3:0] END_INTEL_LAST = 4'd10;
  localparam logic [3:0] END_SREC_LAST  = 4'd1;

  // Header byte slots
  localparam logic [2:0] SLOT_CNT  = 3'd0;
  localparam logic [2:0] SLOT_A3   = 3'd1;
  localparam logic [2:0] SLOT_A2   = 3'd2;
  localparam logic [2:0] SLOT_A1   = 3'd3;
  localparam logic [2:0] SLOT_A0   = 3'd4;
  localparam logic [2:0] SLOT_TYPE = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } out_item_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};  // 'A' - 10
    end
    return c;
  endfunction

  function automatic logic [7:0] intel_end_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = CH_COLON;
      4'd8:    c = 8'h31;  // '1'
      4'd9:    c = 8'h46;  // 'F'
      4'd10:   c = 8'h46;
      default: c = CH_ZERO;
    endcase
    return c;
  endfunction

  // Slot that follows the count byte: address bytes depend on format
  function automatic logic [2:0] first_addr_slot(input logic [1:0] fmt);
    logic [2:0] s;
    case (fmt)
      2'd3:    s = SLOT_A3;
      2'd2:    s = SLOT_A2;
      default: s = SLOT_A1;
    endcase
    return s;
  endfunction

endpackage

[hw/rtl/hre_if.sv]
// ============================================================================
// hre_if: streaming channels of the hex record encoder
// Input channel carries binary bytes, output channel carries ASCII characters.
// ============================================================================
interface hre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_image;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_image, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input end_of_image, output ready);
endinterface

interface hre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

[hw/rtl/hex_record_encoder_unit.sv]
// ============================================================================
// hex_record_encoder_unit: binary byte stream to Intel hex / S-record text
// Buffers bytes into records and emits each record one ASCII character per
// transaction on the output channel.
// ============================================================================
// Output: a byte that closes no record gives no output; output stalls delay the text.
// Throughput: one character per cycle while the output is ready; the input is
//   ready only while the single character sequencer is idle.
// Reset (rst_n low, synchronous): format S1, start address 0, empty buffer.

module hex_record_encoder_unit (
  input  logic              clk,
  input  logic              rst_n,
  hre_in_if.sink            in_ch,
  hre_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LEAD = 4'd1;  // ':' or 'S'
  localparam logic [3:0] ST_TYPE = 4'd2;  // S-record type digit
  localparam logic [3:0] ST_HDR  = 4'd3;  // count, address, Intel type byte
  localparam logic [3:0] ST_DATA = 4'd4;
  localparam logic [3:0] ST_CHK  = 4'd5;
  localparam logic [3:0] ST_CR   = 4'd6;
  localparam logic [3:0] ST_LF   = 4'd7;
  localparam logic [3:0] ST_END  = 4'd8;  // end record body

  localparam int CNT_W = hre_pkg::CNT_W;
  localparam int IDX_W = hre_pkg::IDX_W;

  // Configuration and image state
  logic [1:0]        fmt_r, fmt_nxt;
  logic [31:0]       start_r, start_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]        rchk_r, rchk_nxt;
  logic [7:0]        buf_mem [hre_pkg::RECORD_BYTES];
  logic [7:0]        rd_r;  // buffer entry at the current data index

  // Sequencer state
  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [7:0]        chk_r, chk_nxt;
  logic [2:0]        slot_r, slot_nxt;
  logic [IDX_W-1:0]  didx_r, didx_nxt;
  logic [3:0]        eidx_r, eidx_nxt;
  logic              nib_r, nib_nxt;
  logic              endp_r, endp_nxt;  // end record owed after this record
  logic              endph_r, endph_nxt;  // emitting the end record

  // Output register
  logic              ovalid_r, ovalid_nxt;
  hre_pkg::out_item_t oitem_r, oitem_nxt;

  logic              in_acc;
  logic              adv;
  logic              load;
  logic [7:0]        ld_char;
  logic              ld_last;
  logic [CNT_W-1:0]  cnt_new;
  logic [7:0]        rchk_new;
  logic [7:0]        cur_byte;
  logic [7:0]        hex_out;
  logic [7:0]        chk_sum;
  logic [7:0]        cnt_byte;
  logic [2:0]        last_slot;
  logic              is_intel;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign adv          = !ovalid_r || out_ch.ready;
  assign is_intel     = (fmt_r == hre_pkg::FMT_INTEL);

  assign out_ch.valid    = ovalid_r;
  assign out_ch.out_char = oitem_r.out_char;
  assign out_ch.run_last = oitem_r.run_last;

  assign cnt_new  = cnt_r + {{(CNT_W-1){1'b0}}, in_ch.byte_valid};
  assign rchk_new = rchk_r + (in_ch.byte_valid ? in_ch.data_byte : 8'd0);

  // Count byte: plain length for Intel, length + address bytes + 1 for S
  assign cnt_byte  = is_intel ? {{(8-CNT_W){1'b0}}, len_r}
                              : {{(8-CNT_W){1'b0}}, len_r} + 8'd2 + {6'd0, fmt_r};
  assign last_slot = is_intel ? hre_pkg::SLOT_TYPE : hre_pkg::SLOT_A0;

  // Select the byte on display for the current state
  always_comb begin
    cur_byte = 8'd0;
    case (state_r)
      ST_HDR: begin
        case (slot_r)
          hre_pkg::SLOT_CNT: cur_byte = cnt_byte;
          hre_pkg::SLOT_A3:  cur_byte = addr_r[31:24];
          hre_pkg::SLOT_A2:  cur_byte = addr_r[23:16];
          hre_pkg::SLOT_A1:  cur_byte = addr_r[15:8];
          hre_pkg::SLOT_A0:  cur_byte = addr_r[7:0];
          default:           cur_byte = 8'd0;
        endcase
      end
      ST_DATA: cur_byte = rd_r;
      ST_CHK:  cur_byte = is_intel ? (8'd0 - chk_r) : ~chk_r;
      default: cur_byte = 8'd0;
    endcase
  end

  assign hex_out = hre_pkg::hex_char(nib_r ? cur_byte[3:0] : cur_byte[7:4]);
  // Checksum adder: folds in each header byte; data is summed at accept into rchk_r
  assign chk_sum = chk_r + cur_byte;

  always_comb begin
    fmt_nxt   = fmt_r;
    start_nxt = start_r;
    addr_nxt  = addr_r;
    cnt_nxt   = cnt_r;
    rchk_nxt  = rchk_r;
    state_nxt = state_r;
    len_nxt   = len_r;
    chk_nxt   = chk_r;
    slot_nxt  = slot_r;
    didx_nxt  = didx_r;
    eidx_nxt  = eidx_r;
    nib_nxt   = nib_r;
    endp_nxt  = endp_r;
    endph_nxt = endph_r;
    load      = 1'b0;
    ld_char   = 8'd0;
    ld_last   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt  = cnt_new;
          rchk_nxt = rchk_new;
          if (cnt_new == CNT_W'(hre_pkg::RECORD_BYTES) ||
              (in_ch.end_of_image && cnt_new != '0)) begin
            len_nxt   = cnt_new;
            cnt_nxt   = '0;
            rchk_nxt  = 8'd0;
            chk_nxt   = rchk_new;
            endp_nxt  = in_ch.end_of_image;
            endph_nxt = 1'b0;
            state_nxt = ST_LEAD;
          end else if (in_ch.end_of_image) begin
            eidx_nxt  = 4'd0;
            endph_nxt = 1'b1;
            state_nxt = ST_END;
          end
        end
      end
      ST_LEAD: begin
        if (adv) begin
          load      = 1'b1;
          ld_char   = is_intel ? hre_pkg::CH_COLON : hre_pkg::CH_S;
          slot_nxt  = hre_pkg::SLOT_CNT;
          nib_nxt   = 1'b0;
          state_nxt = is_intel ? ST_HDR : ST_TYPE;
        end
      end
      ST_TYPE: begin
        if (adv) begin
          load      = 1'b1;
          ld_char   = hre_pkg::CH_ZERO | {6'd0, fmt_r};
          state_nxt = ST_HDR;
        end
      end
      ST_HDR: begin
        if (adv) begin
          load    = 1'b1;
          ld_char = hex_out;
          nib_nxt = !nib_r;
          if (nib_r) begin
            chk_nxt = chk_sum;
            if (slot_r == last_slot) begin
              didx_nxt  = '0;
              state_nxt = ST_DATA;
            end else if (slot_r == hre_pkg::SLOT_CNT) begin
              slot_nxt = is_intel ? hre_pkg::SLOT_A1 : hre_pkg::first_addr_slot(fmt_r);
            end else begin
              slot_nxt = slot_r + 3'd1;
            end
          end
        end
      end
      ST_DATA: begin
        if (adv) begin
          load    = 1'b1;
          ld_char = hex_out;
          nib_nxt = !nib_r;
          if (nib_r) begin
            if ({1'b0, didx_r} + CNT_W'(1) == len_r) begin
              state_nxt = ST_CHK;
            end else begin
              didx_nxt = didx_r + IDX_W'(1);
            end
          end
        end
      end
      ST_CHK: begin
        if (adv) begin
          load    = 1'b1;
          ld_char = hex_out;
          nib_nxt = !nib_r;
          if (nib_r) begin
            state_nxt = ST_CR;
          end
        end
      end
      ST_CR: begin
        if (adv) begin
          load      = 1'b1;
          ld_char   = hre_pkg::CH_CR;
          state_nxt = ST_LF;
        end
      end
      ST_LF: begin
        if (adv) begin
          load    = 1'b1;
          ld_char = hre_pkg::CH_LF;
          if (endph_r) begin
            // End record done: the next image starts over
            ld_last   = 1'b1;
            addr_nxt  = start_r;
            endph_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            addr_nxt = addr_r + {{(32-CNT_W){1'b0}}, len_r};
            if (endp_r) begin
              eidx_nxt  = 4'd0;
              endph_nxt = 1'b1;
              endp_nxt  = 1'b0;
              state_nxt = ST_END;
            end else begin
              ld_last   = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_END: begin
        if (adv) begin
          load = 1'b1;
          if (is_intel) begin
            ld_char = hre_pkg::intel_end_char(eidx_r);
          end else begin
            ld_char = (eidx_r == 4'd0) ? hre_pkg::CH_S : hre_pkg::CH_TEN - {6'd0, fmt_r};
          end
          if (eidx_r == (is_intel ? hre_pkg::END_INTEL_LAST : hre_pkg::END_SREC_LAST)) begin
            state_nxt = ST_CR;
          end else begin
            eidx_nxt = eidx_r + 4'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Configuration writes must arrive only while idle; the block itself does not enforce it
    if (cfg_we) begin
      case (cfg_index)
        hre_pkg::CFG_FORMAT: fmt_nxt = cfg_data[1:0];
        hre_pkg::CFG_START: begin
          start_nxt = cfg_data;
          addr_nxt  = cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: load a new character or drop the taken one
  always_comb begin
    ovalid_nxt = ovalid_r;
    oitem_nxt  = oitem_r;
    if (load) begin
      ovalid_nxt         = 1'b1;
      oitem_nxt.out_char = ld_char;
      oitem_nxt.run_last = ld_last;
    end else if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= 2'd1;
      start_r  <= 32'd0;
      addr_r   <= 32'd0;
      cnt_r    <= '0;
      rchk_r   <= 8'd0;
      state_r  <= ST_IDLE;
      endp_r   <= 1'b0;
      endph_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      fmt_r    <= fmt_nxt;
      start_r  <= start_nxt;
      addr_r   <= addr_nxt;
      cnt_r    <= cnt_nxt;
      rchk_r   <= rchk_nxt;
      state_r  <= state_nxt;
      endp_r   <= endp_nxt;
      endph_r  <= endph_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    chk_r   <= chk_nxt;
    slot_r  <= slot_nxt;
    didx_r  <= didx_nxt;
    eidx_r  <= eidx_nxt;
    nib_r   <= nib_nxt;
    oitem_r <= oitem_nxt;
  end

  // Record buffer: write the accepted byte at the fill position; read ahead
  // at the next data index so the entry is registered when it is shown
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.byte_valid) begin
      buf_mem[cnt_r[IDX_W-1:0]] <= in_ch.data_byte;
    end
    rd_r <= buf_mem[didx_nxt];
  end

`ifndef SYNTH
  a_idle_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> cnt_r < CNT_W'(hre_pkg::RECORD_BYTES))
    else $error("buffer full while idle");

  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.end_of_image |=> state_r != ST_IDLE)
    else $error("end of image produced no output");

  a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DATA |-> ({1'b0, didx_r} < len_r))
    else $error("data index beyond record length");

  a_fill_starts_record: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.byte_valid &&
    cnt_r == CNT_W'(hre_pkg::RECORD_BYTES - 1) |=> state_r == ST_LEAD)
    else $error("full buffer did not start a record");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load && ld_last |=> state_r == ST_IDLE)
    else $error("final character without return to idle");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for hex_record_encoder_unit
// Drives byte transactions with random gaps, predicts every ASCII character
// of the Intel hex and S-record text in a local encoder model, and compares
// each output transaction against the oldest predicted character.
// ============================================================================
module tb;

  localparam int         WATCHDOG_LIMIT = 1000;  // quiet cycles before giving up
  localparam int         DRAIN_CYCLES   = 48;    // settle time after all predicted text is out
  localparam int         ITEM_TARGET    = 420;   // input transactions in the run
  localparam logic [1:0] REC_S1         = 2'd1;
  localparam logic [1:0] REC_S2         = 2'd2;
  localparam logic [1:0] REC_S3         = 2'd3;
  localparam logic [7:0] CH_LETTER_A    = 8'h41;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  hre_in_if  in_ch ();
  hre_out_if out_ch ();

  hex_record_encoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running 8 ns clock.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Encoder model: register copies, record buffer, running address/checksum.
  // --------------------------------------------------------------------------
  logic [1:0]  enc_format;
  logic [31:0] enc_start;
  logic [7:0]  rec_bytes [hre_pkg::RECORD_BYTES];
  int          rec_fill;
  logic [31:0] rec_addr;
  logic [7:0]  rec_sum;
  int          chars_this_item;

  hre_pkg::out_item_t expected_chars [$];   // predicted text, oldest first

  int          error_count;
  int          stream_items;         // input transactions sent so far
  int          in_gap_max;
  int          out_stall_max;
  int          quiet_cycles;

  function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return hre_pkg::CH_ZERO + {4'd0, nib};
    end
    return CH_LETTER_A + {4'd0, nib} - 8'd10;
  endfunction

  function automatic void put_ascii(input logic [7:0] c);
    hre_pkg::out_item_t e;
    e.out_char = c;
    e.run_last = 1'b0;
    expected_chars.push_back(e);
    chars_this_item++;
  endfunction

  function automatic void put_hex_byte(input logic [7:0] b);
    put_ascii(nibble_ascii(b[7:4]));
    put_ascii(nibble_ascii(b[3:0]));
  endfunction

  // Emit one data record from the buffer in the format in force right now.
  function automatic void emit_data_record();
    logic [7:0]  len;
    logic [7:0]  chk;
    logic [31:0] a;
    len = rec_fill[7:0];
    a   = rec_addr;
    if (enc_format == hre_pkg::FMT_INTEL) begin
      put_ascii(hre_pkg::CH_COLON);
      put_hex_byte(len);
      put_hex_byte(a[15:8]);
      put_hex_byte(a[7:0]);
      put_ascii(hre_pkg::CH_ZERO);
      put_ascii(hre_pkg::CH_ZERO);
      chk = len + a[15:8] + a[7:0] + rec_sum;
      for (int i = 0; i < rec_fill; i++) put_hex_byte(rec_bytes[i]);
      put_hex_byte(8'h00 - chk);
    end else begin
      put_ascii(hre_pkg::CH_S);
      put_ascii(hre_pkg::CH_ZERO + {6'd0, enc_format});
      chk = len + 8'd2 + {6'd0, enc_format};
      put_hex_byte(chk);
      if (enc_format == REC_S3) begin
        put_hex_byte(a[31:24]);
        chk = chk + a[31:24];
      end
      if (enc_format == REC_S2 || enc_format == REC_S3) begin
        put_hex_byte(a[23:16]);
        chk = chk + a[23:16];
      end
      put_hex_byte(a[15:8]);
      put_hex_byte(a[7:0]);
      chk = chk + a[15:8] + a[7:0] + rec_sum;
      for (int i = 0; i < rec_fill; i++) put_hex_byte(rec_bytes[i]);
      put_hex_byte(~chk);
    end
    put_ascii(hre_pkg::CH_CR);
    put_ascii(hre_pkg::CH_LF);
    rec_addr = rec_addr + rec_fill;
    rec_fill = 0;
    rec_sum  = 8'd0;
  endfunction

  function automatic void emit_end_line();
    if (enc_format == hre_pkg::FMT_INTEL) begin
      // ":00000001FF"
      put_ascii(hre_pkg::CH_COLON);
      put_hex_byte(8'h00);
      put_hex_byte(8'h00);
      put_hex_byte(8'h00);
      put_hex_byte(8'h01);
      put_hex_byte(8'hFF);
    end else begin
      put_ascii(hre_pkg::CH_S);
      put_ascii(hre_pkg::CH_TEN - {6'd0, enc_format});
    end
    put_ascii(hre_pkg::CH_CR);
    put_ascii(hre_pkg::CH_LF);
  endfunction

  // Advance the model by one accepted input transaction.
  function automatic void encode_transaction(input logic [7:0] d, input logic bv,
                                             input logic eoi);
    hre_pkg::out_item_t tail;
    chars_this_item = 0;
    if (bv) begin
      rec_bytes[rec_fill] = d;
      rec_fill++;
      rec_sum = rec_sum + d;
      if (rec_fill >= hre_pkg::RECORD_BYTES) emit_data_record();
    end
    if (eoi) begin
      if (rec_fill != 0) emit_data_record();
      emit_end_line();
      rec_addr = enc_start;
    end
    // Flag the final character of this transaction.
    if (chars_this_item > 0) begin
      tail = expected_chars.pop_back();
      tail.run_last = 1'b1;
      expected_chars.push_back(tail);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting and result checking.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("tb: %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Compare every accepted character with the oldest prediction.
  always @(posedge clk) begin
    hre_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %02h", out_ch.out_char));
      end else begin
        want = expected_chars.pop_front();
        if (out_ch.out_char !== want.out_char)
          report_mismatch($sformatf("out_char %02h, expected %02h",
                                    out_ch.out_char, want.out_char));
        if (out_ch.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %b, expected %b on char %02h",
                                    out_ch.run_last, want.run_last, want.out_char));
      end
    end
  end

  // Watchdog: end the run when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: watchdog expired with %0d chars pending", expected_chars.size());
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int draw_wait(input int max_wait);
    if (max_wait == 0) return 0;
    return $urandom_range(0, max_wait);
  endfunction

  // Receiver: stall a random number of cycles before each character.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_wait(out_stall_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Send one input transaction after a random gap; keep valid high when the
  // gap is zero so back-to-back transactions stream without a bubble.
  task automatic send_item(input logic [7:0] d, input logic bv, input logic eoi);
    int gap;
    gap = draw_wait(in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= d;
    in_ch.byte_valid   <= bv;
    in_ch.end_of_image <= eoi;
    do @(posedge clk); while (!in_ch.ready);
    encode_transaction(d, bv, eoi);
    stream_items++;
  endtask

  // Hold the input idle until every predicted char is out, then let the
  // sequencer settle in case it is still finishing a record.
  task automatic wait_text_drained();
    in_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == hre_pkg::CFG_FORMAT) begin
      enc_format = value[1:0];
    end else begin
      enc_start = value;
      rec_addr  = value;
    end
  endtask

  // Upper bits of the data word are junk; only the low two select the format.
  task automatic write_format(input logic [1:0] fmt);
    logic [31:0] w;
    w      = $urandom();
    w[1:0] = fmt;
    write_reg(hre_pkg::CFG_FORMAT, w);
  endtask

  function automatic logic [31:0] pick_start();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      3:       return 32'h0000_FFF0 | $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 3;
      default: return 15;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Reset defaults: S1 format at address zero.
  task automatic test_reset_defaults();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    wait_text_drained();
  endtask

  // A transaction with neither a byte nor an end must produce nothing.
  task automatic test_ignored_item();
    send_item(8'hA5, 1'b0, 1'b0);
    wait_text_drained();
  endtask

  // End marker with an empty buffer: only the Intel end line.
  task automatic test_empty_end();
    write_format(hre_pkg::FMT_INTEL);
    send_item(8'h5A, 1'b0, 1'b1);
    wait_text_drained();
  endtask

  // Full record in S3 just below the 32-bit wrap, then a short record at the
  // wrapped address and the S7 end line.
  task automatic test_full_record_wrap();
    write_format(REC_S3);
    write_reg(hre_pkg::CFG_START, 32'hFFFF_FFF8);
    for (int i = 0; i < hre_pkg::RECORD_BYTES; i++) send_item(8'(i * 17), 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b1);
    wait_text_drained();
  endtask

  // Buffer bytes in Intel mode, switch to S2 and move the start address
  // before the record goes out: layout and address follow the new settings.
  task automatic test_format_at_emission();
    write_format(hre_pkg::FMT_INTEL);
    write_reg(hre_pkg::CFG_START, 32'h1234_FFF0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'hFE, 1'b1, 1'b0);
    wait_text_drained();
    write_format(REC_S2);
    write_reg(hre_pkg::CFG_START, 32'h00AB_CDEF);
    send_item(8'h3C, 1'b1, 1'b1);
    wait_text_drained();
  endtask

  // Random images across many format/address settings and idle mixes.
  // Images mostly end on a flagged byte; some end on a bare marker, and a few
  // stay open across a configuration change.
  task automatic test_random_images();
    int         phase;
    int         images;
    int         len;
    int         ending;
    logic [1:0] fmt;
    phase = 0;
    while (stream_items < ITEM_TARGET) begin
      wait_text_drained();
      fmt = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
      write_format(fmt);
      if (phase % 3 != 2) write_reg(hre_pkg::CFG_START, pick_start());
      in_gap_max    = pick_idle();
      out_stall_max = pick_idle();
      images = $urandom_range(1, 4);
      repeat (images) begin
        if (stream_items < ITEM_TARGET) begin
          len    = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
                                               : $urandom_range(1, 20);
          ending = $urandom_range(0, 9);  // 0..6 flagged byte, 7..8 marker, 9 open
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
              send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && (ending < 7));
          end
          if (ending == 7 || ending == 8)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
      end
      phase++;
    end
    // Close whatever image is still open.
    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    error_count   = 0;
    stream_items  = 0;
    quiet_cycles  = 0;
    in_gap_max    = 15;
    out_stall_max = 15;

    // Drive every input to a known value from time zero.
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= hre_pkg::CFG_FORMAT;
    cfg_data           <= 32'd0;
    in_ch.valid        <= 1'b0;
    in_ch.data_byte    <= 8'd0;
    in_ch.byte_valid   <= 1'b0;
    in_ch.end_of_image <= 1'b0;

    // Model starts from the reset state of the block.
    enc_format = REC_S1;
    enc_start  = 32'd0;
    rec_addr   = 32'd0;
    rec_fill   = 0;
    rec_sum    = 8'd0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_ignored_item();
    test_empty_end();
    test_full_record_wrap();
    test_format_at_emission();
    test_random_images();

    // Drain: hold the input idle until all text is out, then settle.
    wait_text_drained();

    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
